>>> hw/rtl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by websocket_frame_deframer_core.
`default_nettype none

package wsd_pkg;

	// Parse phase codes
	localparam logic [2:0] PH_HDR0 = 3'd0;
	localparam logic [2:0] PH_HDR1 = 3'd1;
	localparam logic [2:0] PH_EXT  = 3'd2;
	localparam logic [2:0] PH_MASK = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;

	// Length kind codes
	localparam logic [1:0] LEN_SHORT = 2'd0;
	localparam logic [1:0] LEN_16    = 2'd1;
	localparam logic [1:0] LEN_64    = 2'd2;

	// Header field constants
	localparam logic [6:0] LEN7_EXT16  = 7'd126;
	localparam logic [6:0] LEN7_EXT64  = 7'd127;
	localparam logic [3:0] OPC_MAX_DATA = 4'h2;
	localparam logic [2:0] EXT16_BYTES  = 3'd2;
	// 8 extended bytes wrap the 3-bit counter back to zero
	localparam logic [2:0] EXT64_BYTES  = 3'd0;
	localparam logic [2:0] KEY_BYTES    = 3'd4;
	localparam logic [31:0] LEN_SATURATED = 32'hFFFF_FFFF;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

	typedef logic [7:0] byte_t;

endpackage

`default_nettype wire

>>> hw/rtl/websocket_frame_deframer_core.sv
// WebSocket frame deframer, receive side: header parse, unmask, payload delivery.
// Depends on wsd_pkg for phase codes and header constants.
//
// Channel   Dir  Bits  Contents
// s_axis    in   8     tdata[7:0] raw stream byte
// m_axis    out  24+2+1 tdata payload byte / delivered count, tuser opcode, tlast
// cfg       in   16    max_payload write, no read-back
//
// One byte is accepted per cycle unless input stalls; header bytes only update
// parse state, data bytes within max_payload give one item the following cycle.
// The output register decouples the sides: a new byte is taken while a
// result waits, and input stalls only when that register is full and m_axis
// is stalled. Reset clears all parse state and sets max_payload to 1024.
`default_nettype none

module websocket_frame_deframer_core
	import wsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// stream input: [7:0] in_byte
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,
	// stream output: [7:0] payload_byte, [23:8] delivered_count
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,
	// [1:0] frame_opcode
	output logic [1:0]       m_axis_tuser,
	output logic             m_axis_tlast,
	// max_payload register write
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);

	// Parse state
	logic [2:0]  phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        masked_q, masked_d;
	logic [1:0]  len_kind_q, len_kind_d;
	logic [2:0]  cnt_q, cnt_d;
	logic        upper_nz_q, upper_nz_d;
	logic [31:0] frame_len_q, frame_len_d;
	logic [31:0] mask_key_q, mask_key_d;
	logic [31:0] pidx_q, pidx_d;
	logic [15:0] max_payload_q;

	// Output register
	logic        m_valid_q;
	byte_t       out_byte_q;
	logic [1:0]  out_opc_q;
	logic        out_last_q;
	logic [15:0] out_cnt_q;

	// Per-byte results
	logic        accept;
	byte_t       b;
	logic        emit;
	byte_t       emit_byte;
	logic        emit_last;
	logic [31:0] pidx_inc;
	logic [2:0]  cnt_inc;
	logic [2:0]  ext_total;
	logic [31:0] len_shift;
	logic [31:0] len_final;
	byte_t       key_byte;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign b             = s_axis_tdata;
	assign pidx_inc      = pidx_q + 32'd1;
	assign cnt_inc       = cnt_q + 3'd1;
	assign ext_total     = (len_kind_q == LEN_16) ? EXT16_BYTES : EXT64_BYTES;
	assign len_shift     = {frame_len_q[23:0], b};

	// Mask key byte for this index: first key byte sits in the top 8 bits
	always_comb begin
		case (pidx_q[1:0])
			2'd0:    key_byte = mask_key_q[31:24];
			2'd1:    key_byte = mask_key_q[23:16];
			2'd2:    key_byte = mask_key_q[15:8];
			default: key_byte = mask_key_q[7:0];
		endcase
	end

	assign emit_byte = masked_q ? (b ^ key_byte) : b;
	assign emit_last = (pidx_inc == frame_len_q) || (pidx_inc == {16'd0, max_payload_q});

	// Next parse state for the accepted byte
	always_comb begin
		phase_d     = phase_q;
		opcode_d    = opcode_q;
		masked_d    = masked_q;
		len_kind_d  = len_kind_q;
		cnt_d       = cnt_q;
		upper_nz_d  = upper_nz_q;
		frame_len_d = frame_len_q;
		mask_key_d  = mask_key_q;
		pidx_d      = pidx_q;
		len_final   = frame_len_q;
		emit        = 1'b0;
		unique case (phase_q)
			PH_HDR1: begin
				masked_d    = b[7];
				cnt_d       = 3'd0;
				upper_nz_d  = 1'b0;
				frame_len_d = 32'd0;
				if (b[6:0] == LEN7_EXT16) begin
					len_kind_d = LEN_16;
					phase_d    = PH_EXT;
				end else if (b[6:0] == LEN7_EXT64) begin
					len_kind_d = LEN_64;
					phase_d    = PH_EXT;
				end else begin
					len_kind_d  = LEN_SHORT;
					frame_len_d = {25'd0, b[6:0]};
					if (b[7]) begin
						mask_key_d = 32'd0;
						phase_d    = PH_MASK;
					end else begin
						pidx_d  = 32'd0;
						phase_d = (b[6:0] == 7'd0) ? PH_HDR0 : PH_DATA;
					end
				end
			end
			PH_EXT: begin
				// upper half of a 64-bit length only marks overflow
				if (len_kind_q == LEN_64 && !cnt_q[2]) begin
					if (b != 8'd0) begin
						upper_nz_d = 1'b1;
					end
				end else begin
					frame_len_d = len_shift;
				end
				cnt_d = cnt_inc;
				if (cnt_inc == ext_total) begin
					len_final   = (len_kind_q == LEN_64 && upper_nz_d) ? LEN_SATURATED
						: frame_len_d;
					frame_len_d = len_final;
					if (masked_q) begin
						cnt_d      = 3'd0;
						mask_key_d = 32'd0;
						phase_d    = PH_MASK;
					end else begin
						pidx_d  = 32'd0;
						phase_d = (len_final == 32'd0) ? PH_HDR0 : PH_DATA;
					end
				end
			end
			PH_MASK: begin
				mask_key_d = {mask_key_q[23:0], b};
				cnt_d      = cnt_inc;
				if (cnt_inc == KEY_BYTES) begin
					pidx_d  = 32'd0;
					phase_d = (frame_len_q == 32'd0) ? PH_HDR0 : PH_DATA;
				end
			end
			PH_DATA: begin
				emit   = (opcode_q <= OPC_MAX_DATA) && (pidx_q < {16'd0, max_payload_q});
				pidx_d = pidx_inc;
				if (pidx_inc == frame_len_q) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				opcode_d = b[3:0];
				phase_d  = PH_HDR1;
			end
		endcase
	end

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			opcode_q    <= 4'd0;
			masked_q    <= 1'b0;
			len_kind_q  <= LEN_SHORT;
			cnt_q       <= 3'd0;
			upper_nz_q  <= 1'b0;
			frame_len_q <= 32'd0;
			mask_key_q  <= 32'd0;
			pidx_q      <= 32'd0;
		end else if (accept) begin
			phase_q     <= phase_d;
			opcode_q    <= opcode_d;
			masked_q    <= masked_d;
			len_kind_q  <= len_kind_d;
			cnt_q       <= cnt_d;
			upper_nz_q  <= upper_nz_d;
			frame_len_q <= frame_len_d;
			mask_key_q  <= mask_key_d;
			pidx_q      <= pidx_d;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_byte_q <= emit_byte;
			out_opc_q  <= opcode_q[1:0];
			out_last_q <= emit_last;
			out_cnt_q  <= emit_last ? pidx_inc[15:0] : 16'd0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {out_cnt_q, out_byte_q};
	assign m_axis_tuser  = out_opc_q;
	assign m_axis_tlast  = out_last_q;

	// Count is only reported on the last byte of a frame
	a_cnt_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[23:8] == 16'd0))
		else $error("delivered count nonzero on non-last item");

	// Only data opcodes are delivered
	a_data_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser != 2'd3))
		else $error("control opcode delivered");

	// Payload phase is never entered with an empty frame
	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (frame_len_q != 32'd0))
		else $error("payload phase with zero length");

	// A payload byte with a result loads the output register
	a_emit_load: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit) |=> m_valid_q)
		else $error("emitted item lost");

endmodule

`default_nettype wire
